// ===== hdl/scpc_pkg.sv =====
// Shared types, widths and constants for the scan polar-to-cartesian unit.
// No dependencies; every other file in hdl/ imports this package.
package scpc_pkg;

    localparam int RANGE_W               = 24;
    localparam int ANGLE_W               = 16;
    localparam int POS_W                 = 25;
    localparam int RED_W                 = 8;
    localparam int GUARD                 = 8;
    localparam int ANGLE_FRAC            = 8;   // 2^-16 turn to 2^-24 turn
    localparam int XY_W                  = RANGE_W + GUARD + 3;
    localparam int Z_W                   = 26;
    localparam int TABLE_LEN             = 24;
    localparam int CORDIC_STAGES_DEFAULT = 16;
    localparam int CFG_IDX_W             = 8;
    localparam int CFG_DATA_W            = 24;
    localparam int PROD_W                = 2 * RANGE_W;

    localparam logic [RANGE_W-1:0] GAIN_INV     = 24'd10188014;
    localparam logic [PROD_W-1:0]  GAIN_ROUND   = 48'd8388608;
    localparam logic [RANGE_W-1:0] RANGE_TOP    = 24'hFFFFFF;
    localparam logic [ANGLE_W-1:0] ANGLE_QUART  = 16'h4000;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF   = 16'h8000;
    localparam logic [RED_W-1:0]   RED_ON       = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_START = 8'd0,
        REG_ANGLE_STEP  = 8'd1,
        REG_RANGE_LOWER = 8'd2,
        REG_RANGE_UPPER = 8'd3
    } cfg_reg_t;

    // Sideband that travels with each item down the chain
    typedef struct packed {
        logic valid;
        logic ok;
        logic last;
    } meta_t;

    // atan(2^-i) in 2^-24 turn units
    function automatic logic [Z_W-1:0] atan_entry(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 26'd2097152;
            1:       v = 26'd1238021;
            2:       v = 26'd654136;
            3:       v = 26'd332050;
            4:       v = 26'd166669;
            5:       v = 26'd83416;
            6:       v = 26'd41718;
            7:       v = 26'd20860;
            8:       v = 26'd10430;
            9:       v = 26'd5215;
            10:      v = 26'd2608;
            11:      v = 26'd1304;
            12:      v = 26'd652;
            13:      v = 26'd326;
            14:      v = 26'd163;
            15:      v = 26'd81;
            16:      v = 26'd41;
            17:      v = 26'd20;
            18:      v = 26'd10;
            19:      v = 26'd5;
            20:      v = 26'd3;
            21:      v = 26'd1;
            22:      v = 26'd1;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

    // Drop guard bits rounding half up, then clamp to the coordinate range
    function automatic logic signed [POS_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
        localparam logic signed [XY_W-GUARD:0] R_MAX = (XY_W-GUARD+1)'((2 ** (POS_W - 1)) - 1);
        localparam logic signed [XY_W-GUARD:0] R_MIN = (XY_W-GUARD+1)'(-(2 ** (POS_W - 1)));
        logic signed [XY_W:0]       t;
        logic signed [XY_W-GUARD:0] r;
        logic signed [POS_W-1:0]    o;
        t = {v[XY_W-1], v} + (XY_W+1)'(2 ** (GUARD - 1));
        r = t[XY_W:GUARD];
        if (r > R_MAX)
            o = R_MAX[POS_W-1:0];
        else if (r < R_MIN)
            o = R_MIN[POS_W-1:0];
        else
            o = r[POS_W-1:0];
        return o;
    endfunction

endpackage

// ===== hdl/scpc_front.sv =====
// Front end: config registers, angle accumulator, range window, gain scaling
// and quadrant folding. Feeds the first CORDIC cell. Uses scpc_pkg.
module scpc_front
    import scpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  logic [RANGE_W-1:0]       range_sample,
    input  logic                     range_missing,
    input  logic                     last_of_scan,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output logic signed [XY_W-1:0]   x_out,
    output logic signed [XY_W-1:0]   y_out,
    output logic signed [Z_W-1:0]    z_out,
    output meta_t                    meta_out
);

    logic [ANGLE_W-1:0] angle_start_reg;
    logic [ANGLE_W-1:0] angle_step_reg;
    logic [RANGE_W-1:0] range_lower_reg;
    logic [RANGE_W-1:0] range_upper_reg;
    logic [ANGLE_W-1:0] current_angle_reg;
    logic [ANGLE_W-1:0] current_angle_next;
    logic               scan_starting_reg;
    logic               scan_starting_next;

    logic               accept;
    logic [ANGLE_W-1:0] angle_sel;
    logic               in_ok;

    meta_t              a_meta_reg;
    logic [RANGE_W-1:0] a_range_reg;
    logic [ANGLE_W-1:0] a_angle_reg;

    meta_t              b_meta_reg;
    logic [RANGE_W-1:0] b_scaled_reg;
    logic [ANGLE_W-1:0] b_angle_reg;
    logic [PROD_W-1:0]  prod;

    logic               flip;
    logic [ANGLE_W-1:0] quad_angle;
    logic [ANGLE_W-1:0] fold_angle;
    logic signed [XY_W-1:0] x_mag;
    logic signed [XY_W-1:0] x_next;
    logic signed [Z_W-1:0]  z_next;

    meta_t                  c_meta_reg;
    logic signed [XY_W-1:0] c_x_reg;
    logic signed [Z_W-1:0]  c_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
            range_lower_reg <= '0;
            range_upper_reg <= RANGE_TOP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ANGLE_START: angle_start_reg <= cfg_data[ANGLE_W-1:0];
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_data[ANGLE_W-1:0];
                REG_RANGE_LOWER: range_lower_reg <= cfg_data[RANGE_W-1:0];
                REG_RANGE_UPPER: range_upper_reg <= cfg_data[RANGE_W-1:0];
                default:         ;
            endcase
        end
    end

    // First sample of a scan restarts from the configured start angle
    always_comb
    begin
        accept             = in_valid && advance;
        angle_sel          = scan_starting_reg ? angle_start_reg : current_angle_reg;
        in_ok              = !range_missing && (range_sample >= range_lower_reg)
                             && (range_sample <= range_upper_reg);
        current_angle_next = current_angle_reg;
        scan_starting_next = scan_starting_reg;
        if (accept)
        begin
            current_angle_next = angle_sel + angle_step_reg;
            scan_starting_next = last_of_scan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_angle_reg <= '0;
            scan_starting_reg <= 1'b1;
        end
        else
        begin
            current_angle_reg <= current_angle_next;
            scan_starting_reg <= scan_starting_next;
        end
    end

    // Stage A: capture item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_meta_reg <= '0;
        else if (advance)
            a_meta_reg <= '{valid: in_valid, ok: in_ok, last: last_of_scan};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_range_reg <= range_sample;
            a_angle_reg <= angle_sel;
        end
    end

    // Stage B: scale range by inverse CORDIC gain
    assign prod = a_range_reg * GAIN_INV + GAIN_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_meta_reg <= '0;
        else if (advance)
            b_meta_reg <= a_meta_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_scaled_reg <= prod[PROD_W-1:RANGE_W];
            b_angle_reg  <= a_angle_reg;
        end
    end

    // Stage C: fold angles in the back half-turn onto the negated vector
    always_comb
    begin
        quad_angle = b_angle_reg + ANGLE_QUART;
        flip       = quad_angle[ANGLE_W-1];
        fold_angle = flip ? (b_angle_reg + ANGLE_HALF) : b_angle_reg;
        x_mag      = {{(XY_W-RANGE_W-GUARD){1'b0}}, b_scaled_reg, {GUARD{1'b0}}};
        x_next     = flip ? -x_mag : x_mag;
        z_next     = {{(Z_W-ANGLE_W-ANGLE_FRAC){fold_angle[ANGLE_W-1]}}, fold_angle,
                      {ANGLE_FRAC{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_meta_reg <= '0;
        else if (advance)
            c_meta_reg <= b_meta_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_x_reg <= x_next;
            c_z_reg <= z_next;
        end
    end

    assign x_out    = c_x_reg;
    assign y_out    = '0;
    assign z_out    = c_z_reg;
    assign meta_out = c_meta_reg;

endmodule

// ===== hdl/scpc_cordic_cell.sv =====
// One CORDIC rotation cell: shift-add step with a fixed shift and table angle.
// Uses scpc_pkg for widths, the meta struct and the arctangent table.
module scpc_cordic_cell
    import scpc_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    input  meta_t                  meta_in,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out,
    output meta_t                  meta_out
);

    localparam logic [Z_W-1:0] ATAN = atan_entry(SHIFT);

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    meta_t                  meta_reg;

    // Arithmetic shifts floor toward minus infinity
    always_comb
    begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!z_in[Z_W-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - $signed(ATAN);
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + $signed(ATAN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meta_reg <= '0;
        else if (advance)
            meta_reg <= meta_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign meta_out = meta_reg;

endmodule

// ===== hdl/scan_polar_to_cartesian_unit.sv =====
// Top level: front end, chain of CORDIC cells and the output register.
// Depends on scpc_pkg, scpc_front and scpc_cordic_cell.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   range_sample, range_missing, last_of_scan
//  out       source     out_valid / out_stall x_position, y_position, point_valid,
//                                             red_level, scan_end
//  cfg       sink       cfg_write             cfg_index, cfg_data
//
// One item per cycle unless the output stalls; the path registers are the three front
// stages, one register per CORDIC cell and the output register.
// The whole chain moves as one: a stalled output holds every stage and raises in_stall.
// Reset clears valid flags, the angle accumulator and the config registers, but sets
// the range upper bound to all ones; the next sample after reset starts a scan.
module scan_polar_to_cartesian_unit
    import scpc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [RANGE_W-1:0]      range_sample,
    input  logic                    range_missing,
    input  logic                    last_of_scan,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] x_position,
    output logic signed [POS_W-1:0] y_position,
    output logic                    point_valid,
    output logic [RED_W-1:0]        red_level,
    output logic                    scan_end,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int NCELL = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic                   advance;
    logic signed [XY_W-1:0] x_chain [0:NCELL];
    logic signed [XY_W-1:0] y_chain [0:NCELL];
    logic signed [Z_W-1:0]  z_chain [0:NCELL];
    meta_t                  meta_chain [0:NCELL];

    logic                    out_valid_reg;
    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic                    point_valid_reg;
    logic [RED_W-1:0]        red_reg;
    logic                    scan_end_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    scpc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .range_sample  (range_sample),
        .range_missing (range_missing),
        .last_of_scan  (last_of_scan),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .x_out         (x_chain[0]),
        .y_out         (y_chain[0]),
        .z_out         (z_chain[0]),
        .meta_out      (meta_chain[0])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        scpc_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .x_in     (x_chain[i]),
            .y_in     (y_chain[i]),
            .z_in     (z_chain[i]),
            .meta_in  (meta_chain[i]),
            .x_out    (x_chain[i+1]),
            .y_out    (y_chain[i+1]),
            .z_out    (z_chain[i+1]),
            .meta_out (meta_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= meta_chain[NCELL].valid;
    end

    // Rejected samples give zero coordinates and zero colour
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scan_end_reg <= meta_chain[NCELL].last;
            if (meta_chain[NCELL].ok)
            begin
                x_reg           <= round_sat(x_chain[NCELL]);
                y_reg           <= round_sat(y_chain[NCELL]);
                point_valid_reg <= 1'b1;
                red_reg         <= RED_ON;
            end
            else
            begin
                x_reg           <= '0;
                y_reg           <= '0;
                point_valid_reg <= 1'b0;
                red_reg         <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_position  = x_reg;
    assign y_position  = y_reg;
    assign point_valid = point_valid_reg;
    assign red_level   = red_reg;
    assign scan_end    = scan_end_reg;

endmodule

// ===== hdl/scpc_checker.sv =====
// Port-level checks for scan_polar_to_cartesian_unit, attached by bind.
// Depends on scpc_pkg and the top level's port names.
module scpc_checker
    import scpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [POS_W-1:0] x_position,
    input  logic signed [POS_W-1:0] y_position,
    input  logic                    point_valid,
    input  logic [RED_W-1:0]        red_level,
    input  logic                    scan_end
);

    // A stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_position) && $stable(y_position)
            && $stable(point_valid) && $stable(red_level) && $stable(scan_end))
        else $error("stalled output item changed");

    // A full, stalled output must back-pressure the input
    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> x_position == '0 && y_position == '0 && red_level == '0)
        else $error("rejected point carries nonzero data");

    a_valid_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> red_level == RED_ON)
        else $error("valid point without full red level");

endmodule

bind scan_polar_to_cartesian_unit scpc_checker u_scpc_checker (.*);
